// ----- sv/union_find_cycle_detect_defines.svh -----
// Assertion macros for the union-find cycle detector checker.
`ifndef UNION_FIND_CYCLE_DETECT_DEFINES_SVH
`define UNION_FIND_CYCLE_DETECT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define UFCD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define UFCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/ufcd_pkg.sv -----
// Package with the shared constants, state encoding and store port types.
package ufcd_pkg;

   // Number of nodes in the forest and the width of a node index.
   localparam int NODES  = 256;
   localparam int NODE_W = $clog2(NODES);

   // Sequencer states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_FIND,
      S_COMP,
      S_DONE,
      S_OUT
   } state_type;

   // Input actions.
   localparam logic ACT_EDGE  = 1'b0;
   localparam logic ACT_CLEAR = 1'b1;

   // Read request to the parent store.
   typedef struct packed {
      logic              en;
      logic [NODE_W-1:0] addr;
   } rd_req_type;

   // Write request to the parent store: the entry becomes a child of link.
   typedef struct packed {
      logic              en;
      logic [NODE_W-1:0] addr;
      logic [NODE_W-1:0] link;
   } wr_req_type;

   // Registered read answer from the parent store.
   typedef struct packed {
      logic              is_root;
      logic [NODE_W-1:0] link;
   } rd_rsp_type;

endpackage

// ----- sv/union_find_cycle_detect.sv -----
// Union-find cycle detector: the top level with the find, compress and link sequencer.
//
// Each edge word finds the root of node_a and then of node_b in a parent store
// of 256 entries, rewriting every entry on each walked path to point straight at
// its root, then links the first root under the second, or, when the roots are
// equal, reports that the edge closes a cycle and sets the sticky cycle flag.
// The store has one registered read port. A clear word resets the store at once
// (root marks are flip-flops) and passes its all-zero result through S_OUT to
// the output register. One word is processed at a time; a finished result waits
// in the output register while the next word is taken.
module union_find_cycle_detect (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_action,
   input  logic [7:0] req_node_a,
   input  logic [7:0] req_node_b,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_closes_cycle,
   output logic       rsp_cycle_seen,
   output logic [7:0] rsp_root_a,
   output logic [7:0] rsp_root_b
);

   ufcd_pkg::state_type state_ff, state_in;

   logic [ufcd_pkg::NODE_W-1:0] b_ff, b_in;
   logic [ufcd_pkg::NODE_W-1:0] start_ff, start_in;
   logic [ufcd_pkg::NODE_W-1:0] cur_ff, cur_in;
   logic [ufcd_pkg::NODE_W-1:0] node_ff, node_in;
   logic [ufcd_pkg::NODE_W-1:0] root_ff, root_in;
   logic [ufcd_pkg::NODE_W-1:0] ra_ff, ra_in;
   logic                        second_ff, second_in;
   logic                        flag_ff, flag_in;

   logic                        res_closes_ff, res_closes_in;
   logic                        res_seen_ff, res_seen_in;
   logic [ufcd_pkg::NODE_W-1:0] res_ra_ff, res_ra_in;
   logic [ufcd_pkg::NODE_W-1:0] res_rb_ff, res_rb_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_closes_ff, rsp_closes_in;
   logic                        rsp_seen_ff, rsp_seen_in;
   logic [ufcd_pkg::NODE_W-1:0] rsp_ra_ff, rsp_ra_in;
   logic [ufcd_pkg::NODE_W-1:0] rsp_rb_ff, rsp_rb_in;

   logic                 store_clear;
   logic                 roots_equal;
   ufcd_pkg::rd_req_type rd_req;
   ufcd_pkg::wr_req_type wr_req;
   ufcd_pkg::rd_rsp_type rd_rsp;

   ufcd_parent_store u_store (
      .clock  (clock),
      .reset  (reset),
      .clear  (store_clear),
      .rd_req (rd_req),
      .wr_req (wr_req),
      .rd_rsp (rd_rsp)
   );

   assign roots_equal = (ra_ff == root_ff);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ufcd_pkg::S_IDLE;
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Walk pointers, pending result and output word.
   always_ff @(posedge clock) begin
      b_ff          <= b_in;
      start_ff      <= start_in;
      cur_ff        <= cur_in;
      node_ff       <= node_in;
      root_ff       <= root_in;
      ra_ff         <= ra_in;
      second_ff     <= second_in;
      res_closes_ff <= res_closes_in;
      res_seen_ff   <= res_seen_in;
      res_ra_ff     <= res_ra_in;
      res_rb_ff     <= res_rb_in;
      rsp_closes_ff <= rsp_closes_in;
      rsp_seen_ff   <= rsp_seen_in;
      rsp_ra_ff     <= rsp_ra_in;
      rsp_rb_ff     <= rsp_rb_in;
   end

   // Sequencer: clear, or root walk, rewrite walk, then link or cycle report, then output.
   always_comb begin
      state_in      = state_ff;
      b_in          = b_ff;
      start_in      = start_ff;
      cur_in        = cur_ff;
      node_in       = node_ff;
      root_in       = root_ff;
      ra_in         = ra_ff;
      second_in     = second_ff;
      flag_in       = flag_ff;
      res_closes_in = res_closes_ff;
      res_seen_in   = res_seen_ff;
      res_ra_in     = res_ra_ff;
      res_rb_in     = res_rb_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_closes_in = rsp_closes_ff;
      rsp_seen_in   = rsp_seen_ff;
      rsp_ra_in     = rsp_ra_ff;
      rsp_rb_in     = rsp_rb_ff;
      req_ready     = 1'b0;
      store_clear   = 1'b0;
      rd_req        = '0;
      wr_req        = '0;

      case (state_ff)
         ufcd_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_action == ufcd_pkg::ACT_CLEAR) begin
                  store_clear   = 1'b1;
                  flag_in       = 1'b0;
                  res_closes_in = 1'b0;
                  res_seen_in   = 1'b0;
                  res_ra_in     = '0;
                  res_rb_in     = '0;
                  state_in      = ufcd_pkg::S_OUT;
               end else begin
                  b_in        = req_node_b;
                  start_in    = req_node_a;
                  cur_in      = req_node_a;
                  second_in   = 1'b0;
                  rd_req.en   = 1'b1;
                  rd_req.addr = req_node_a;
                  state_in    = ufcd_pkg::S_FIND;
               end
            end
         end

         // The entry at cur_ff has been read: stop at a root or follow the link.
         ufcd_pkg::S_FIND: begin
            if (rd_rsp.is_root) begin
               root_in = cur_ff;
               if (cur_ff == start_ff) begin
                  state_in = ufcd_pkg::S_DONE;
               end else begin
                  node_in     = start_ff;
                  rd_req.en   = 1'b1;
                  rd_req.addr = start_ff;
                  state_in    = ufcd_pkg::S_COMP;
               end
            end else begin
               cur_in      = rd_rsp.link;
               rd_req.en   = 1'b1;
               rd_req.addr = rd_rsp.link;
            end
         end

         // The entry at node_ff has been read: point it at the root, move on.
         // The next read address is its old parent, never the entry written.
         ufcd_pkg::S_COMP: begin
            wr_req.en   = 1'b1;
            wr_req.addr = node_ff;
            wr_req.link = root_ff;
            if (rd_rsp.link == root_ff) begin
               state_in = ufcd_pkg::S_DONE;
            end else begin
               node_in     = rd_rsp.link;
               rd_req.en   = 1'b1;
               rd_req.addr = rd_rsp.link;
            end
         end

         // One find is complete: start the second one or link the two roots.
         ufcd_pkg::S_DONE: begin
            if (!second_ff) begin
               ra_in       = root_ff;
               second_in   = 1'b1;
               start_in    = b_ff;
               cur_in      = b_ff;
               rd_req.en   = 1'b1;
               rd_req.addr = b_ff;
               state_in    = ufcd_pkg::S_FIND;
            end else begin
               if (roots_equal) begin
                  flag_in = 1'b1;
               end else begin
                  wr_req.en   = 1'b1;
                  wr_req.addr = ra_ff;
                  wr_req.link = root_ff;
               end
               res_closes_in = roots_equal;
               res_seen_in   = flag_ff | roots_equal;
               res_ra_in     = ra_ff;
               res_rb_in     = root_ff;
               state_in      = ufcd_pkg::S_OUT;
            end
         end

         // Hand the result to the output register once it is free.
         ufcd_pkg::S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_closes_in = res_closes_ff;
               rsp_seen_in   = res_seen_ff;
               rsp_ra_in     = res_ra_ff;
               rsp_rb_in     = res_rb_ff;
               state_in      = ufcd_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = ufcd_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_closes_cycle = rsp_closes_ff;
   assign rsp_cycle_seen   = rsp_seen_ff;
   assign rsp_root_a       = rsp_ra_ff;
   assign rsp_root_b       = rsp_rb_ff;

endmodule

// ----- sv/ufcd_parent_store.sv -----
// Parent store: link memory plus one root mark per entry.
module ufcd_parent_store (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  clear,
   input  ufcd_pkg::rd_req_type  rd_req,
   input  ufcd_pkg::wr_req_type  wr_req,
   output ufcd_pkg::rd_rsp_type  rd_rsp
);

   // Parent index memory; its content is only meaningful for non-root entries.
   logic [ufcd_pkg::NODE_W-1:0] link_mem [ufcd_pkg::NODES];

   // A set bit means the entry has been linked under a parent since the last clear.
   logic [ufcd_pkg::NODES-1:0] linked_ff;

   logic                        rd_root_ff;
   logic [ufcd_pkg::NODE_W-1:0] rd_link_ff;

   // Memory write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         link_mem[wr_req.addr] <= wr_req.link;
      end
      if (rd_req.en) begin
         rd_link_ff <= link_mem[rd_req.addr];
         rd_root_ff <= ~linked_ff[rd_req.addr];
      end
   end

   // Root marks: cleared at once by reset or a clear action.
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         linked_ff <= '0;
      end else if (wr_req.en) begin
         linked_ff[wr_req.addr] <= 1'b1;
      end
   end

   assign rd_rsp.is_root = rd_root_ff;
   assign rd_rsp.link    = rd_link_ff;

endmodule

// ----- sv/ufcd_checker.sv -----
// Port-level checker for the union-find cycle detector and its bind.
`include "union_find_cycle_detect_defines.svh"

module ufcd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_closes_cycle,
   input logic       rsp_cycle_seen,
   input logic [7:0] rsp_root_a,
   input logic [7:0] rsp_root_b
);

   // A stalled result word holds until it is taken.
   `UFCD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable({rsp_closes_cycle, rsp_cycle_seen, rsp_root_a, rsp_root_b}),
      "result word changed while stalled")

   // Only one word is in process: the cycle after acceptance takes no word.
   `UFCD_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready,
      "input taken while a word is in process")

   // An edge that closes a cycle has equal roots and raises the sticky flag.
   `UFCD_ASSERT_NOW(a_cycle_roots, clock, reset, rsp_valid && rsp_closes_cycle,
      (rsp_root_a == rsp_root_b) && rsp_cycle_seen,
      "cycle reported with distinct roots or flag low")

   // Equal roots without a cycle only come from a clear, whose word is all zero.
   `UFCD_ASSERT_NOW(a_equal_roots, clock, reset,
      rsp_valid && !rsp_closes_cycle && (rsp_root_a == rsp_root_b),
      !rsp_cycle_seen && (rsp_root_a == 8'd0), "equal roots without a cycle")

endmodule

bind union_find_cycle_detect ufcd_checker u_ufcd_checker (.*);

// ----- dv/union_find_cycle_detect_tb.sv -----
// Self-checking testbench for the union-find cycle detector.
module union_find_cycle_detect_tb;

   // Result fields of one word, in the order the block reports them.
   typedef struct packed {
      logic                        closes_cycle;
      logic                        cycle_seen;
      logic [ufcd_pkg::NODE_W-1:0] root_a;
      logic [ufcd_pkg::NODE_W-1:0] root_b;
   } verdict_type;

   localparam int HOLD_CYCLES = 300;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic       req_action;
   logic [7:0] req_node_a;
   logic [7:0] req_node_b;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_closes_cycle;
   logic       rsp_cycle_seen;
   logic [7:0] rsp_root_a;
   logic [7:0] rsp_root_b;

   // Shadow copy of the forest kept by the predictor.
   logic                        root_mark [ufcd_pkg::NODES];
   logic [ufcd_pkg::NODE_W-1:0] parent_link [ufcd_pkg::NODES];
   logic                        cycle_sticky;

   verdict_type expected_verdicts [$];
   int          failures = 0;
   bit          no_idle = 1'b0;
   int          hold_requests = 0;

   union_find_cycle_detect dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_node_a      (req_node_a),
      .req_node_b      (req_node_b),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_closes_cycle(rsp_closes_cycle),
      .rsp_cycle_seen  (rsp_cycle_seen),
      .rsp_root_a      (rsp_root_a),
      .rsp_root_b      (rsp_root_b)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Make every node a root again and drop the sticky flag.
   function automatic void clear_forest();
      for (int i = 0; i < ufcd_pkg::NODES; i++) begin
         root_mark[i]   = 1'b1;
         parent_link[i] = '0;
      end
      cycle_sticky = 1'b0;
   endfunction

   // Walk up to the root, then point every node on the path straight at it.
   function automatic logic [ufcd_pkg::NODE_W-1:0] find_and_compress(
         input logic [ufcd_pkg::NODE_W-1:0] start);
      logic [ufcd_pkg::NODE_W-1:0] cur;
      logic [ufcd_pkg::NODE_W-1:0] node;
      logic [ufcd_pkg::NODE_W-1:0] nxt;
      int                          steps;
      cur   = start;
      steps = 0;
      while (!root_mark[cur] && steps < ufcd_pkg::NODES) begin
         cur = parent_link[cur];
         steps++;
      end
      node  = start;
      steps = 0;
      while (node != cur && !root_mark[node] && steps < ufcd_pkg::NODES) begin
         nxt               = parent_link[node];
         parent_link[node] = cur;
         node              = nxt;
         steps++;
      end
      return cur;
   endfunction

   // Apply one accepted word to the shadow forest and return its result.
   function automatic verdict_type predict_verdict(input logic act, input logic [7:0] a,
                                                   input logic [7:0] b);
      verdict_type v;
      logic [ufcd_pkg::NODE_W-1:0] ra;
      logic [ufcd_pkg::NODE_W-1:0] rb;
      v = '0;
      if (act == ufcd_pkg::ACT_CLEAR) begin
         clear_forest();
         return v;
      end
      ra = find_and_compress(a);
      rb = find_and_compress(b);
      if (ra == rb) begin
         v.closes_cycle = 1'b1;
         cycle_sticky   = 1'b1;
      end else begin
         root_mark[ra]   = 1'b0;
         parent_link[ra] = rb;
      end
      v.cycle_seen = cycle_sticky;
      v.root_a     = ra;
      v.root_b     = rb;
      return v;
   endfunction

   // Offer one word after a random gap and record its result once accepted.
   task automatic send_word(input logic act, input logic [7:0] a, input logic [7:0] b);
      int gap;
      gap = 0;
      if (!no_idle) begin
         while ($urandom_range(99) < 36) gap++;
      end
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= act;
      req_node_a <= a;
      req_node_b <= b;
      do @(posedge clock); while (!req_ready);
      expected_verdicts.insert(expected_verdicts.size(), predict_verdict(act, a, b));
   endtask

   // Stop offering words and wait until every expected result has come back.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
   endtask

   // Edge word with both endpoints drawn from a window of the node space.
   task automatic send_pool_edge(input int base, input int span);
      send_word(ufcd_pkg::ACT_EDGE, 8'(base + $urandom_range(span - 1)),
                8'(base + $urandom_range(span - 1)));
   endtask

   // Result side: random stalls, quiet stretches and requested long hold-offs.
   always @(negedge clock) begin
      static int hold_seen = 0;
      static int hold_left = 0;
      if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (no_idle) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= 36);
      end
   end

   // Compare each delivered result word with the oldest expectation.
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_verdicts.size() == 0) begin
            $error("result word with no expectation waiting");
            failures++;
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_closes_cycle !== want.closes_cycle) begin
               $error("closes_cycle: expected %0d, actual %0d", want.closes_cycle,
                      rsp_closes_cycle);
               failures++;
            end
            if (rsp_cycle_seen !== want.cycle_seen) begin
               $error("cycle_seen: expected %0d, actual %0d", want.cycle_seen,
                      rsp_cycle_seen);
               failures++;
            end
            if (rsp_root_a !== want.root_a) begin
               $error("root_a: expected %0d, actual %0d", want.root_a, rsp_root_a);
               failures++;
            end
            if (rsp_root_b !== want.root_b) begin
               $error("root_b: expected %0d, actual %0d", want.root_b, rsp_root_b);
               failures++;
            end
         end
      end
   end

   // Clears and self loops, including the flag dropping after a clear.
   task automatic test_clear_and_self_loops();
      send_word(ufcd_pkg::ACT_CLEAR, 8'd0, 8'd0);
      send_word(ufcd_pkg::ACT_EDGE, 8'd0, 8'd0);
      send_word(ufcd_pkg::ACT_EDGE, 8'd255, 8'd255);
      send_word(ufcd_pkg::ACT_CLEAR, 8'd255, 8'd255);
      send_word(ufcd_pkg::ACT_EDGE, 8'd7, 8'd9);
      drain_results();
   endtask

   // Extreme and alternating node indexes, joined both ways round.
   task automatic test_extreme_nodes();
      send_word(ufcd_pkg::ACT_EDGE, 8'd0, 8'd255);
      send_word(ufcd_pkg::ACT_EDGE, 8'd255, 8'd0);
      send_word(ufcd_pkg::ACT_EDGE, 8'd170, 8'd85);
      send_word(ufcd_pkg::ACT_EDGE, 8'd85, 8'd170);
      send_word(ufcd_pkg::ACT_EDGE, 8'd0, 8'd170);
      send_word(ufcd_pkg::ACT_EDGE, 8'd255, 8'd85);
      drain_results();
   endtask

   // A short chain that the next find must walk and compress.
   task automatic test_chain_compression();
      send_word(ufcd_pkg::ACT_CLEAR, 8'd0, 8'd0);
      for (int i = 1; i < 6; i++) send_word(ufcd_pkg::ACT_EDGE, 8'(i), 8'(i + 1));
      send_word(ufcd_pkg::ACT_EDGE, 8'd1, 8'd6);
      send_word(ufcd_pkg::ACT_EDGE, 8'd1, 8'd9);
      send_word(ufcd_pkg::ACT_EDGE, 8'd3, 8'd9);
      send_word(ufcd_pkg::ACT_EDGE, 8'd2, 8'd4);
      drain_results();
   endtask

   // One chain through every node, then finds from its far end.
   task automatic test_full_chain();
      send_word(ufcd_pkg::ACT_CLEAR, 8'd0, 8'd0);
      for (int i = 0; i < ufcd_pkg::NODES - 1; i++) begin
         send_word(ufcd_pkg::ACT_EDGE, 8'(i), 8'(i + 1));
      end
      send_word(ufcd_pkg::ACT_EDGE, 8'd0, 8'd255);
      send_word(ufcd_pkg::ACT_EDGE, 8'd128, 8'd0);
      drain_results();
   endtask

   // The receiver holds off for a long stretch while words keep coming.
   task automatic test_output_backpressure();
      no_idle = 1'b1;
      @(negedge clock);
      hold_requests++;
      for (int i = 0; i < 24; i++) send_pool_edge(40, 12);
      no_idle = 1'b0;
      drain_results();
   endtask

   // Both sides run without idling.
   task automatic test_back_to_back();
      no_idle = 1'b1;
      send_word(ufcd_pkg::ACT_CLEAR, 8'd0, 8'd0);
      for (int i = 0; i < 150; i++) send_pool_edge(100, 24);
      drain_results();
      no_idle = 1'b0;
   endtask

   // Phases of random forests: small and wide pools, chain bursts and noise.
   task automatic test_random_forests(input int count);
      int sent;
      int kind;
      int base;
      int span;
      int len;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(3);
         base = $urandom_range(255);
         len  = $urandom_range(20, 80);
         if ($urandom_range(1) == 1) begin
            send_word(ufcd_pkg::ACT_CLEAR, 8'($urandom), 8'($urandom));
            sent++;
         end
         case (kind)
            0, 1: begin
               span = (kind == 0) ? $urandom_range(2, 16) : $urandom_range(17, 64);
               for (int i = 0; i < len; i++) begin
                  if ($urandom_range(99) < 3) begin
                     send_word(ufcd_pkg::ACT_CLEAR, 8'($urandom), 8'($urandom));
                  end else if ($urandom_range(99) < 8) begin
                     send_word(ufcd_pkg::ACT_EDGE, 8'($urandom), 8'($urandom));
                  end else begin
                     send_pool_edge(base, span);
                  end
               end
               sent += len;
            end
            2: begin
               for (int i = 0; i < len; i++) begin
                  send_word(ufcd_pkg::ACT_EDGE, 8'($urandom), 8'($urandom));
               end
               sent += len;
            end
            default: begin
               // Build a chain and then ask for roots from its tail.
               span = $urandom_range(4, 40);
               for (int i = 0; i < span; i++) begin
                  send_word(ufcd_pkg::ACT_EDGE, 8'(base + i), 8'(base + i + 1));
               end
               send_word(ufcd_pkg::ACT_EDGE, 8'(base), 8'(base + span));
               send_word(ufcd_pkg::ACT_EDGE, 8'(base + $urandom_range(span)), 8'($urandom));
               send_word(ufcd_pkg::ACT_EDGE, 8'(base + $urandom_range(span)), 8'(base));
               sent += span + 3;
            end
         endcase
      end
      drain_results();
   endtask

   // Main sequence: reset once, run each test in turn, then report.
   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_action = ufcd_pkg::ACT_EDGE;
      req_node_a = '0;
      req_node_b = '0;
      rsp_ready  = 1'b0;
      clear_forest();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_clear_and_self_loops();
      test_extreme_nodes();
      test_chain_compression();
      test_output_backpressure();
      test_back_to_back();
      test_full_chain();
      test_random_forests(1050);

      drain_results();
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("union_find_cycle_detect verification clean");
      end else begin
         $display("union_find_cycle_detect verification failed");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #2000000;
      $display("union_find_cycle_detect verification failed");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+sv
sv/ufcd_pkg.sv
sv/ufcd_parent_store.sv
sv/union_find_cycle_detect.sv
sv/ufcd_checker.sv
dv/union_find_cycle_detect_tb.sv
